// ----- design/crast_pkg.sv -----
// Shared types and constants of the circle rasterizer.
package crast_pkg;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  localparam int PIXELS_PER_STEP = 8;
  localparam int PIX_IDX_BITS = $clog2(PIXELS_PER_STEP);
  localparam logic [PIX_IDX_BITS-1:0] LAST_PIX = PIX_IDX_BITS'(PIXELS_PER_STEP - 1);

  localparam int DEC_EXTRA = 5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

endpackage

// ----- design/circle_rasterizer.sv -----
// Top level of the midpoint circle rasterizer.
// A start beat (action 0) loads centre and radius and gives no pixels. Each
// advance beat (action 1) of an active circle gives eight pixel beats, one per
// cycle while out_stall is low, through the single pixel output register. Steps
// wait in a two-entry queue, so in_stall rises only when two steps are pending;
// a start or an idle advance queues no step. The pixels of a step pass through
// the queue entry and then the pixel output register. circle_done marks all
// eight pixels of the final octant step; later advances give nothing until the
// next start.
module circle_rasterizer #(
  parameter int COORD_BITS = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [COORD_BITS-1:0]        center_x,
  input  logic [COORD_BITS-1:0]        center_y,
  input  logic [COORD_BITS-1:0]        radius,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                         last_of_step,
  output logic                         circle_done
);
  import crast_pkg::*;

  q_status_t             qs;
  logic                  push, pop, push_done, head_done;
  logic [COORD_BITS-1:0] push_cx, push_cy, push_x, push_y;
  logic [COORD_BITS-1:0] head_cx, head_cy, head_x, head_y;

  crast_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .qs        (qs),
    .push      (push),
    .push_cx   (push_cx),
    .push_cy   (push_cy),
    .push_x    (push_x),
    .push_y    (push_y),
    .push_done (push_done)
  );

  crast_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cx   (push_cx),
    .push_cy   (push_cy),
    .push_x    (push_x),
    .push_y    (push_y),
    .push_done (push_done),
    .pop       (pop),
    .qs        (qs),
    .head_cx   (head_cx),
    .head_cy   (head_cy),
    .head_x    (head_x),
    .head_y    (head_y),
    .head_done (head_done)
  );

  crast_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .qs           (qs),
    .head_cx      (head_cx),
    .head_cy      (head_cy),
    .head_x       (head_x),
    .head_y       (head_y),
    .head_done    (head_done),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule

// ----- design/crast_front.sv -----
// Front end: takes input beats, holds the octant state and queues octant steps.
module crast_front #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic [COORD_BITS-1:0]   center_x,
  input  logic [COORD_BITS-1:0]   center_y,
  input  logic [COORD_BITS-1:0]   radius,
  input  crast_pkg::q_status_t    qs,
  output logic                    push,
  output logic [COORD_BITS-1:0]   push_cx,
  output logic [COORD_BITS-1:0]   push_cy,
  output logic [COORD_BITS-1:0]   push_x,
  output logic [COORD_BITS-1:0]   push_y,
  output logic                    push_done
);
  import crast_pkg::*;

  localparam int DB = COORD_BITS + DEC_EXTRA;

  logic signed [COORD_BITS:0] octant_x, octant_y;
  logic signed [COORD_BITS:0] octant_x_next, octant_y_next;
  logic signed [DB-1:0]       decision, decision_next, decision_start;
  logic signed [DB-1:0]       x_ext, y_ext;
  logic [COORD_BITS-1:0]      origin_x, origin_y;
  logic                       active;
  logic                       accept, is_start, done;

  assign in_stall = qs.full;
  assign accept   = in_valid && !qs.full;
  assign is_start = (action_t'(action) == ACT_START);

  always_comb begin
    x_ext = DB'(octant_x);
    y_ext = DB'(octant_y);
    octant_x_next = octant_x + (COORD_BITS + 1)'(1);
    if (decision <= 0) begin
      decision_next = decision + (x_ext <<< 2) + DB'(6);
      octant_y_next = octant_y;
    end else begin
      decision_next = decision + ((x_ext - y_ext) <<< 2) + DB'(10);
      octant_y_next = octant_y - (COORD_BITS + 1)'(1);
    end
    done = octant_x_next > octant_y_next;
    decision_start = DB'(3) - (DB'(radius) <<< 1);
  end

  assign push      = accept && !is_start && active;
  assign push_cx   = origin_x;
  assign push_cy   = origin_y;
  assign push_x    = octant_x[COORD_BITS-1:0];
  assign push_y    = octant_y[COORD_BITS-1:0];
  assign push_done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        active <= 1'b1;
      end else if (active) begin
        active <= !done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_start) begin
        origin_x <= center_x;
        origin_y <= center_y;
        octant_x <= '0;
        octant_y <= (COORD_BITS + 1)'(radius);
        decision <= decision_start;
      end else if (active) begin
        octant_x <= octant_x_next;
        octant_y <= octant_y_next;
        decision <= decision_next;
      end
    end
  end

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (push && push_done) |=> !active)
    else $error("active still set after final octant step");

  a_push_needs_active: assert property (@(posedge clk) disable iff (rst)
    push |-> (active && !qs.full))
    else $error("step queued without circle or into full queue");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (accept && is_start) |=> active)
    else $error("start beat did not arm circle");

endmodule

// ----- design/crast_queue.sv -----
// Short step queue between front end and pixel back end.
module crast_queue #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [COORD_BITS-1:0]   push_cx,
  input  logic [COORD_BITS-1:0]   push_cy,
  input  logic [COORD_BITS-1:0]   push_x,
  input  logic [COORD_BITS-1:0]   push_y,
  input  logic                    push_done,
  input  logic                    pop,
  output crast_pkg::q_status_t    qs,
  output logic [COORD_BITS-1:0]   head_cx,
  output logic [COORD_BITS-1:0]   head_cy,
  output logic [COORD_BITS-1:0]   head_x,
  output logic [COORD_BITS-1:0]   head_y,
  output logic                    head_done
);
  import crast_pkg::*;

  localparam int EW = 4 * COORD_BITS + 1;

  logic [EW-1:0]        entry [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_BITS'(1);
  endfunction

  assign qs.valid = (count != '0);
  assign qs.full  = (count == QCNT_BITS'(QUEUE_DEPTH));

  assign {head_cx, head_cy, head_x, head_y, head_done} = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= {push_cx, push_cy, push_x, push_y, push_done};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qs.valid)
    else $error("pop from empty queue");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - QCNT_BITS'(1))
    else $error("queue count not lowered on pop");

endmodule

// ----- design/crast_back.sv -----
// Back end: expands each queued step into eight mirrored pixel beats.
module crast_back #(
  parameter int COORD_BITS = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  crast_pkg::q_status_t       qs,
  input  logic [COORD_BITS-1:0]      head_cx,
  input  logic [COORD_BITS-1:0]      head_cy,
  input  logic [COORD_BITS-1:0]      head_x,
  input  logic [COORD_BITS-1:0]      head_y,
  input  logic                       head_done,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic                       last_of_step,
  output logic                       circle_done
);
  import crast_pkg::*;

  localparam int OB = COORD_BITS + 2;

  logic [PIX_IDX_BITS-1:0] idx;
  logic                    out_adv, load;
  logic [OB-1:0]           cx_e, cy_e, col, row;
  logic [OB-1:0]           px_next, py_next;

  assign out_adv = !out_valid || !out_stall;
  assign load    = out_adv && qs.valid;
  assign pop     = load && (idx == LAST_PIX);

  always_comb begin
    cx_e = OB'(head_cx);
    cy_e = OB'(head_cy);
    col  = idx[2] ? OB'(head_y) : OB'(head_x);
    row  = idx[2] ? OB'(head_x) : OB'(head_y);
    px_next = idx[0] ? (cx_e - col) : (cx_e + col);
    py_next = idx[1] ? (cy_e - row) : (cy_e + row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_adv) begin
        out_valid <= qs.valid;
      end
      if (load) begin
        idx <= idx + PIX_IDX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x      <= px_next;
      pixel_y      <= py_next;
      last_of_step <= (idx == LAST_PIX);
      circle_done  <= head_done;
    end
  end

  a_idx_has_step: assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> qs.valid)
    else $error("pixel index advanced without queued step");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == '0))
    else $error("pixel index not wrapped after last beat");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("loaded pixel not presented");

endmodule
